// File: rtl/core/sad_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sad_pkg: shared types and constants for the spectral angle unit
// Sample and accumulator widths, the sum bundle handed from front to back,
// the back-end state type and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package sad_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int ACC_W        = 48;
    localparam int QUEUE_DEPTH  = 2;
    localparam int CORDIC_STEPS = 30;
    localparam int ROOT_W       = 32;
    localparam int CW_W         = 34;
    localparam int ANG_W        = 16;

    localparam logic [ACC_W-1:0]        ENERGY_MAX = {ACC_W{1'b1}};
    localparam logic signed [ACC_W-1:0] DOT_MAX    = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] DOT_MIN    = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic signed [34:0]      PI_Q30     = 35'sd3373259426;
    localparam logic [ANG_W-1:0]        ANGLE_MAX  = 16'd51472;

    typedef struct packed {
        logic signed [ACC_W-1:0] dot;
        logic [ACC_W-1:0]        pe;
        logic [ACC_W-1:0]        re;
    } sums_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQRT_P,
        ST_SQRT_R,
        ST_MUL,
        ST_NORM,
        ST_DIV,
        ST_SQR,
        ST_SQRT_S,
        ST_CORDIC,
        ST_FIN,
        ST_HOLD
    } back_state_t;

    // Truncated arctangent of 2^-i in Q.30 radians.
    function automatic logic [29:0] atan_q30(input logic [4:0] i);
        logic [29:0] v;
        case (i)
            5'd0:    v = 30'd843314856;
            5'd1:    v = 30'd497837829;
            5'd2:    v = 30'd263043836;
            5'd3:    v = 30'd133525158;
            5'd4:    v = 30'd67021686;
            5'd5:    v = 30'd33543515;
            5'd6:    v = 30'd16775850;
            5'd7:    v = 30'd8388437;
            5'd8:    v = 30'd4194282;
            5'd9:    v = 30'd2097149;
            5'd10:   v = 30'd1048575;
            5'd11:   v = 30'd524287;
            5'd12:   v = 30'd262143;
            5'd13:   v = 30'd131071;
            5'd14:   v = 30'd65535;
            5'd15:   v = 30'd32767;
            5'd16:   v = 30'd16383;
            5'd17:   v = 30'd8191;
            5'd18:   v = 30'd4095;
            5'd19:   v = 30'd2047;
            5'd20:   v = 30'd1023;
            5'd21:   v = 30'd511;
            5'd22:   v = 30'd255;
            5'd23:   v = 30'd127;
            5'd24:   v = 30'd63;
            5'd25:   v = 30'd31;
            5'd26:   v = 30'd15;
            5'd27:   v = 30'd8;
            5'd28:   v = 30'd4;
            5'd29:   v = 30'd2;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/core/sad_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sad_front: band accumulator
// Multiplies each band pair in a registered stage, then adds the products
// into saturating dot and energy sums; the last band pushes the sums out.
// ----------------------------------------------------------------------------
module sad_front
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [sad_pkg::SAMPLE_W-1:0] pixel_sample,
    input  logic signed [sad_pkg::SAMPLE_W-1:0] ref_sample,
    input  logic                                last_band,
    output logic                                push_valid,
    input  logic                                push_ready,
    output sad_pkg::sums_t                      push_data
);

    logic                    p1_valid_reg;
    logic                    p1_last_reg;
    logic signed [31:0]      pp_reg;
    logic signed [31:0]      rr_reg;
    logic signed [31:0]      pr_reg;
    logic signed [sad_pkg::ACC_W-1:0] dot_reg;
    logic [sad_pkg::ACC_W-1:0] pe_reg;
    logic [sad_pkg::ACC_W-1:0] re_reg;

    logic                    advance;
    logic [sad_pkg::ACC_W:0] pe_sum;
    logic [sad_pkg::ACC_W:0] re_sum;
    logic signed [sad_pkg::ACC_W:0] dot_sum;
    logic [sad_pkg::ACC_W-1:0] pe_next;
    logic [sad_pkg::ACC_W-1:0] re_next;
    logic signed [sad_pkg::ACC_W-1:0] dot_next;

    // The final band of a pair waits here when the queue is full.
    assign advance    = p1_valid_reg && (!p1_last_reg || push_ready);
    assign in_ready   = !p1_valid_reg || advance;
    assign push_valid = p1_valid_reg && p1_last_reg;

    always_comb
    begin
        pe_sum  = {1'b0, pe_reg} + {{(sad_pkg::ACC_W-30){1'b0}}, pp_reg[30:0]};
        re_sum  = {1'b0, re_reg} + {{(sad_pkg::ACC_W-30){1'b0}}, rr_reg[30:0]};
        dot_sum = {dot_reg[sad_pkg::ACC_W-1], dot_reg}
                + {{(sad_pkg::ACC_W-31){pr_reg[31]}}, pr_reg};
        pe_next = pe_sum[sad_pkg::ACC_W] ? sad_pkg::ENERGY_MAX : pe_sum[sad_pkg::ACC_W-1:0];
        re_next = re_sum[sad_pkg::ACC_W] ? sad_pkg::ENERGY_MAX : re_sum[sad_pkg::ACC_W-1:0];
        if (dot_sum[sad_pkg::ACC_W] != dot_sum[sad_pkg::ACC_W-1])
        begin
            dot_next = dot_sum[sad_pkg::ACC_W] ? sad_pkg::DOT_MIN : sad_pkg::DOT_MAX;
        end
        else
        begin
            dot_next = dot_sum[sad_pkg::ACC_W-1:0];
        end
        push_data.dot = dot_next;
        push_data.pe  = pe_next;
        push_data.re  = re_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            pp_reg      <= pixel_sample * pixel_sample;
            rr_reg      <= ref_sample * ref_sample;
            pr_reg      <= pixel_sample * ref_sample;
            p1_last_reg <= last_band;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            dot_reg      <= '0;
            pe_reg       <= '0;
            re_reg       <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                p1_valid_reg <= in_valid;
            end
            if (advance)
            begin
                if (p1_last_reg)
                begin
                    dot_reg <= '0;
                    pe_reg  <= '0;
                    re_reg  <= '0;
                end
                else
                begin
                    dot_reg <= dot_next;
                    pe_reg  <= pe_next;
                    re_reg  <= re_next;
                end
            end
        end
    end

endmodule

// File: rtl/core/sad_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sad_queue: short queue of finished sums
// Holds completed signature sums between the accumulator and the angle unit
// so that each side can stall on its own. Entries shift toward the head.
// ----------------------------------------------------------------------------
module sad_queue
#(
    parameter int DEPTH = sad_pkg::QUEUE_DEPTH
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  sad_pkg::sums_t push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output sad_pkg::sums_t pop_data
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    sad_pkg::sums_t   ent_reg [DEPTH];
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;
    logic [CNT_W-1:0] wr_idx;

    assign push_ready = count_reg < CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = ent_reg[0];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign wr_idx     = count_reg - CNT_W'(do_pop);

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            if (do_push && wr_idx == CNT_W'(i))
            begin
                ent_reg[i] <= push_data;
            end
            else if (do_pop && i < DEPTH - 1)
            begin
                ent_reg[i] <= ent_reg[(i + 1) % DEPTH];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
        end
    end

endmodule

// File: rtl/core/sad_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sad_back: angle sequencer
// Turns one set of sums into an angle: two norm square roots, their product,
// normalization, a restoring divide for the cosine, a square root for the
// sine and a CORDIC vectoring loop, all on shared iterative hardware.
// ----------------------------------------------------------------------------
module sad_back
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           pop_valid,
    output logic                           pop_ready,
    input  sad_pkg::sums_t                 pop_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [sad_pkg::ANG_W-1:0]      out_angle,
    output logic                           out_zero_norm
);

    sad_pkg::back_state_t state_reg, state_next;

    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] sq_op_reg, sq_op_next;
    logic [34:0] sq_rem_reg, sq_rem_next;
    logic [31:0] sq_root_reg, sq_root_next;
    logic [31:0] sp_reg, sp_next;
    logic [31:0] sr_reg, sr_next;
    logic [63:0] den_reg, den_next;
    logic [63:0] n_reg, n_next;
    logic [32:0] drem_reg, drem_next;
    logic [30:0] q_reg, q_next;
    logic signed [sad_pkg::CW_W-1:0] x_reg, x_next;
    logic signed [sad_pkg::CW_W-1:0] y_reg, y_next;
    logic signed [sad_pkg::CW_W-1:0] z_reg, z_next;
    logic        neg_reg, neg_next;
    logic signed [sad_pkg::ACC_W-1:0] dot_reg, dot_next;
    logic [sad_pkg::ACC_W-1:0] re_reg, re_next;
    logic [sad_pkg::ANG_W-1:0] res_reg, res_next;
    logic        zn_reg, zn_next;
    logic        out_valid_reg;
    logic [sad_pkg::ANG_W-1:0] out_angle_reg;
    logic        out_zn_reg;

    logic [34:0] sq_shift;
    logic [34:0] sq_trial;
    logic        sq_fit;
    logic [34:0] sq_rem_step;
    logic [31:0] sq_root_step;
    logic        sq_done;
    logic [33:0] div_cur;
    logic        div_fit;
    logic [33:0] div_rem_step;
    logic [30:0] q_step;
    logic [61:0] cc;
    logic [sad_pkg::ACC_W-1:0] dot_abs;
    logic signed [sad_pkg::CW_W-1:0] dx;
    logic signed [sad_pkg::CW_W-1:0] dy;
    logic signed [sad_pkg::CW_W-1:0] atan_v;
    logic signed [34:0] ang;
    logic signed [34:0] ang_clip;
    logic [34:0] ang_round;
    logic        out_free;

    assign out_free      = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign out_angle     = out_angle_reg;
    assign out_zero_norm = out_zn_reg;

    // Shared arithmetic for the iterative states.
    always_comb
    begin
        sq_shift     = {sq_rem_reg[32:0], sq_op_reg[63:62]};
        sq_trial     = {1'b0, sq_root_reg, 2'b01};
        sq_fit       = sq_shift >= sq_trial;
        sq_rem_step  = sq_fit ? sq_shift - sq_trial : sq_shift;
        sq_root_step = {sq_root_reg[30:0], sq_fit};
        sq_done      = cnt_reg == 6'd31;

        // The first divide step compares the clamped numerator itself.
        div_cur      = (cnt_reg == '0) ? {1'b0, drem_reg} : {drem_reg, 1'b0};
        div_fit      = div_cur >= {2'b00, den_reg[31:0]};
        div_rem_step = div_fit ? div_cur - {2'b00, den_reg[31:0]} : div_cur;
        q_step       = {q_reg[29:0], div_fit};

        cc      = q_reg * q_reg;
        dot_abs = dot_reg[sad_pkg::ACC_W-1] ? sad_pkg::ACC_W'(-dot_reg)
                                            : sad_pkg::ACC_W'(dot_reg);

        dx     = y_reg >>> cnt_reg[4:0];
        dy     = x_reg >>> cnt_reg[4:0];
        atan_v = {4'b0000, sad_pkg::atan_q30(cnt_reg[4:0])};

        ang = neg_reg ? sad_pkg::PI_Q30 - {z_reg[sad_pkg::CW_W-1], z_reg}
                      : {z_reg[sad_pkg::CW_W-1], z_reg};
        if (ang < 0)
        begin
            ang_clip = '0;
        end
        else if (ang > sad_pkg::PI_Q30)
        begin
            ang_clip = sad_pkg::PI_Q30;
        end
        else
        begin
            ang_clip = ang;
        end
        ang_round = 35'(ang_clip) + 35'd32768;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sad_pkg::ST_IDLE:
            begin
                if (pop_valid)
                begin
                    if (pop_data.pe == '0 || pop_data.re == '0)
                    begin
                        state_next = sad_pkg::ST_HOLD;
                    end
                    else
                    begin
                        state_next = sad_pkg::ST_SQRT_P;
                    end
                end
            end
            sad_pkg::ST_SQRT_P:
            begin
                if (sq_done)
                begin
                    state_next = sad_pkg::ST_SQRT_R;
                end
            end
            sad_pkg::ST_SQRT_R:
            begin
                if (sq_done)
                begin
                    state_next = sad_pkg::ST_MUL;
                end
            end
            sad_pkg::ST_MUL:    state_next = sad_pkg::ST_NORM;
            sad_pkg::ST_NORM:
            begin
                if (den_reg[63:32] == '0)
                begin
                    state_next = sad_pkg::ST_DIV;
                end
            end
            sad_pkg::ST_DIV:
            begin
                if (cnt_reg == 6'd30)
                begin
                    state_next = sad_pkg::ST_SQR;
                end
            end
            sad_pkg::ST_SQR:    state_next = sad_pkg::ST_SQRT_S;
            sad_pkg::ST_SQRT_S:
            begin
                if (sq_done)
                begin
                    state_next = sad_pkg::ST_CORDIC;
                end
            end
            sad_pkg::ST_CORDIC:
            begin
                if (cnt_reg == 6'(sad_pkg::CORDIC_STEPS - 1))
                begin
                    state_next = sad_pkg::ST_FIN;
                end
            end
            sad_pkg::ST_FIN:    state_next = sad_pkg::ST_HOLD;
            sad_pkg::ST_HOLD:
            begin
                if (out_free)
                begin
                    state_next = sad_pkg::ST_IDLE;
                end
            end
            default:            state_next = sad_pkg::ST_IDLE;
        endcase
    end

    // Datapath and handshake outputs.
    always_comb
    begin
        pop_ready    = 1'b0;
        cnt_next     = cnt_reg;
        sq_op_next   = sq_op_reg;
        sq_rem_next  = sq_rem_reg;
        sq_root_next = sq_root_reg;
        sp_next      = sp_reg;
        sr_next      = sr_reg;
        den_next     = den_reg;
        n_next       = n_reg;
        drem_next    = drem_reg;
        q_next       = q_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        z_next       = z_reg;
        neg_next     = neg_reg;
        dot_next     = dot_reg;
        re_next      = re_reg;
        res_next     = res_reg;
        zn_next      = zn_reg;
        case (state_reg)
            sad_pkg::ST_IDLE:
            begin
                pop_ready    = 1'b1;
                dot_next     = pop_data.dot;
                re_next      = pop_data.re;
                neg_next     = pop_data.dot[sad_pkg::ACC_W-1];
                sq_op_next   = {pop_data.pe, 16'h0000};
                sq_rem_next  = '0;
                sq_root_next = '0;
                cnt_next     = '0;
                res_next     = '0;
                zn_next      = pop_data.pe == '0 || pop_data.re == '0;
            end
            sad_pkg::ST_SQRT_P, sad_pkg::ST_SQRT_R, sad_pkg::ST_SQRT_S:
            begin
                sq_op_next   = {sq_op_reg[61:0], 2'b00};
                sq_rem_next  = sq_rem_step;
                sq_root_next = sq_root_step;
                cnt_next     = cnt_reg + 6'd1;
                if (sq_done)
                begin
                    cnt_next     = '0;
                    sq_rem_next  = '0;
                    sq_root_next = '0;
                    if (state_reg == sad_pkg::ST_SQRT_P)
                    begin
                        sp_next    = sq_root_step;
                        sq_op_next = {re_reg, 16'h0000};
                    end
                    else if (state_reg == sad_pkg::ST_SQRT_R)
                    begin
                        sr_next = sq_root_step;
                    end
                    else
                    begin
                        x_next = sad_pkg::CW_W'(q_reg);
                        y_next = sad_pkg::CW_W'(sq_root_step);
                        z_next = '0;
                    end
                end
            end
            sad_pkg::ST_MUL:
            begin
                den_next = sp_reg * sr_reg;
                n_next   = {dot_abs, 16'h0000};
            end
            sad_pkg::ST_NORM:
            begin
                cnt_next = '0;
                q_next   = '0;
                if (den_reg[63:32] != '0)
                begin
                    den_next = den_reg >> 1;
                    n_next   = n_reg >> 1;
                end
                else
                begin
                    // Cosine magnitude above one is clamped to one.
                    drem_next = (n_reg > den_reg) ? den_reg[32:0] : n_reg[32:0];
                end
            end
            sad_pkg::ST_DIV:
            begin
                drem_next = div_rem_step[32:0];
                q_next    = q_step;
                cnt_next  = (cnt_reg == 6'd30) ? '0 : cnt_reg + 6'd1;
            end
            sad_pkg::ST_SQR:
            begin
                sq_op_next   = (64'd1 << 60) - {2'b00, cc};
                sq_rem_next  = '0;
                sq_root_next = '0;
                cnt_next     = '0;
            end
            sad_pkg::ST_CORDIC:
            begin
                if (!y_reg[sad_pkg::CW_W-1])
                begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + atan_v;
                end
                else
                begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - atan_v;
                end
                cnt_next = cnt_reg + 6'd1;
            end
            sad_pkg::ST_FIN:
            begin
                if (ang_round[31:16] > sad_pkg::ANGLE_MAX)
                begin
                    res_next = sad_pkg::ANGLE_MAX;
                end
                else
                begin
                    res_next = ang_round[31:16];
                end
            end
            sad_pkg::ST_HOLD:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        cnt_reg     <= cnt_next;
        sq_op_reg   <= sq_op_next;
        sq_rem_reg  <= sq_rem_next;
        sq_root_reg <= sq_root_next;
        sp_reg      <= sp_next;
        sr_reg      <= sr_next;
        den_reg     <= den_next;
        n_reg       <= n_next;
        drem_reg    <= drem_next;
        q_reg       <= q_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        z_reg       <= z_next;
        neg_reg     <= neg_next;
        dot_reg     <= dot_next;
        re_reg      <= re_next;
        res_reg     <= res_next;
        zn_reg      <= zn_next;
        if (state_reg == sad_pkg::ST_HOLD && out_free)
        begin
            out_angle_reg <= res_reg;
            out_zn_reg    <= zn_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sad_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == sad_pkg::ST_HOLD && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// File: rtl/core/spectral_angle_distance_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spectral_angle_distance_unit: spectral angle mapper
// Accumulates one signature pair band by band and reports the angle between
// the pixel and reference signatures in unsigned Q2.14 radians.
// ----------------------------------------------------------------------------
// Usage: each s_axis transfer carries one band (pixel and reference sample);
// tlast marks the final band of a pair. The accumulator takes one band per
// cycle unless a final band is held back by a full queue.
// After a final band the sums enter a queue of QUEUE_DEPTH pairs. The angle
// sequencer then takes one pair at a time through a pop, three 32-step
// square roots, normalization, a 31-step divide, 30 CORDIC steps and the
// multiply, square, finish and hold steps; a pair with zero energy goes
// straight from the pop to the hold step. Each pair gives one m_axis
// transfer: angle in tdata, zero-norm flag in tuser.
// Pairs shorter than the sequence length stall s_axis once the queue fills.
// Reset clears the sums, the queue and the output valid flag; the block is
// ready for bands right after reset. When m_axis is stalled the finished
// result waits in the output register while the accumulator keeps running.
// ----------------------------------------------------------------------------
module spectral_angle_distance_unit
#(
    parameter int QUEUE_DEPTH = sad_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // [15:0] pixel_sample, [31:16] ref_sample
    input  logic        s_axis_tlast,  // last_band
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // [15:0] angle
    output logic        m_axis_tuser   // zero_norm
);

    logic           push_valid;
    logic           push_ready;
    sad_pkg::sums_t push_data;
    logic           pop_valid;
    logic           pop_ready;
    sad_pkg::sums_t pop_data;

    sad_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .pixel_sample (s_axis_tdata[15:0]),
        .ref_sample   (s_axis_tdata[31:16]),
        .last_band    (s_axis_tlast),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_data    (push_data)
    );

    sad_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    sad_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_data      (pop_data),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_angle     (m_axis_tdata),
        .out_zero_norm (m_axis_tuser)
    );

endmodule
